/* design/bpsb_pkg.sv */
// ----------------------------------------------------------------------------
// Bit-packed stream buffer package
// Shared sizes, action codes, the queued command type and a mask helper.
// ----------------------------------------------------------------------------
package bpsb_pkg;

    localparam int STORE_BITS      = 4096;
    localparam int MAX_ACCESS_BITS = 64;
    localparam int WORD_BITS       = 64;
    localparam int STORE_WORDS     = (STORE_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int BANK_DEPTH      = STORE_WORDS / 2;
    localparam int POS_W           = 13;
    localparam int CNT_W           = 7;
    localparam int ACT_W           = 2;
    localparam int OFF_W           = $clog2(WORD_BITS);
    localparam int WIDX_W          = $clog2(STORE_WORDS);
    localparam int BANK_AW         = WIDX_W - 1;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0] CAP_RESET = POS_W'(STORE_BITS);
    localparam logic [POS_W-1:0] STORE_LIMIT = POS_W'(STORE_BITS);
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ACCESS_BITS);

    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEEK   = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [POS_W-1:0]     start;
        logic [CNT_W-1:0]     count;
        logic [WORD_BITS-1:0] value;
        logic [POS_W-1:0]     position;
        logic                 status;
    } t_cmd;

    // Ones in the low n bits; a count of a full word or more gives all ones.
    function automatic logic [WORD_BITS-1:0] count_mask(input logic [CNT_W-1:0] n);
        logic [WORD_BITS-1:0] m;
        if (n >= CNT_W'(WORD_BITS)) begin
            m = '1;
        end else begin
            m = ({{(WORD_BITS-1){1'b0}}, 1'b1} << n[OFF_W-1:0]) - 1'b1;
        end
        return m;
    endfunction

endpackage

/* design/bpsb_ifs.sv */
// ----------------------------------------------------------------------------
// Bit-packed stream buffer channel interfaces
// Request and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bpsb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] write_value;
    logic [6:0]  bit_count;
    logic [12:0] seek_position;

    modport source (output valid, action, write_value, bit_count, seek_position,
                    input ready);
    modport sink   (input valid, action, write_value, bit_count, seek_position,
                    output ready);
endinterface

interface bpsb_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_data;
    logic [6:0]  bits_done;
    logic [12:0] position;
    logic        status;

    modport source (output valid, read_data, bits_done, position, status,
                    input ready);
    modport sink   (input valid, read_data, bits_done, position, status,
                    output ready);
endinterface

/* design/bpsb_ram.sv */
// ----------------------------------------------------------------------------
// Bit-packed stream buffer RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module bpsb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/bpsb_front.sv */
// ----------------------------------------------------------------------------
// Bit-packed stream buffer front end
// Accepts requests, keeps length, read pointer and capacity, and issues
// fully resolved storage commands to the queue.
// ----------------------------------------------------------------------------
module bpsb_front
    import bpsb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [POS_W-1:0] i_cfg_wr_data,
    bpsb_in_if.sink          i_item,
    input  logic             i_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic [POS_W-1:0] r_len;
    logic [POS_W-1:0] r_rptr;
    logic [POS_W-1:0] r_capacity;
    logic [POS_W-1:0] n_len;
    logic [POS_W-1:0] n_rptr;

    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] cap;
    logic [POS_W-1:0] free_bits;
    logic [POS_W-1:0] avail;
    logic [CNT_W-1:0] rd_cnt;

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    always_comb begin
        cnt       = (i_item.bit_count > MAX_COUNT) ? MAX_COUNT : i_item.bit_count;
        cap       = (r_capacity > STORE_LIMIT) ? STORE_LIMIT : r_capacity;
        free_bits = (r_len >= cap) ? '0 : cap - r_len;
        avail     = r_len - r_rptr;
        rd_cnt    = (POS_W'(cnt) > avail) ? avail[CNT_W-1:0] : cnt;

        n_len          = r_len;
        n_rptr         = r_rptr;
        o_cmd.op       = OP_NONE;
        o_cmd.start    = r_len;
        o_cmd.count    = '0;
        o_cmd.value    = i_item.write_value;
        o_cmd.position = r_len;
        o_cmd.status   = 1'b0;

        case (i_item.action)
            ACT_APPEND: begin
                if (POS_W'(cnt) > free_bits) begin
                    o_cmd.status = 1'b1;
                end else begin
                    o_cmd.op       = OP_WRITE;
                    o_cmd.count    = cnt;
                    n_len          = r_len + POS_W'(cnt);
                    o_cmd.position = n_len;
                end
            end
            ACT_READ: begin
                o_cmd.op    = OP_READ;
                o_cmd.start = r_rptr;
                o_cmd.count = rd_cnt;
                n_rptr      = r_rptr + POS_W'(rd_cnt);
            end
            ACT_SEEK: begin
                n_rptr         = (i_item.seek_position > r_len) ? r_len
                                                                : i_item.seek_position;
                o_cmd.position = n_rptr;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_rptr     <= '0;
            r_capacity <= CAP_RESET;
        end else begin
            if (o_push) begin
                r_len  <= n_len;
                r_rptr <= n_rptr;
            end
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
        end
    end

endmodule

/* design/bpsb_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Bit-packed stream buffer command queue
// Short register queue between the front end and the storage engine.
// ----------------------------------------------------------------------------
module bpsb_cmd_fifo
    import bpsb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* design/bpsb_back.sv */
// ----------------------------------------------------------------------------
// Bit-packed stream buffer storage engine
// Reads the two adjacent words a command touches from even and odd banks,
// merges append data or extracts read data, and registers the result.
// ----------------------------------------------------------------------------
module bpsb_back
    import bpsb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_head,
    input  logic      i_empty,
    output logic      o_pop,
    bpsb_out_if.source o_result
);

    typedef enum logic {
        ST_ISSUE,
        ST_EXEC
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic   r_out_valid;
    logic [WORD_BITS-1:0] r_read_data;
    logic [CNT_W-1:0]     r_bits_done;
    logic [POS_W-1:0]     r_position;
    logic                 r_status;

    logic [WIDX_W-1:0]    head_w;
    logic [WIDX_W-1:0]    head_w1;
    logic [BANK_AW-1:0]   rd_addr0;
    logic [BANK_AW-1:0]   rd_addr1;
    logic [WORD_BITS-1:0] rd_data0;
    logic [WORD_BITS-1:0] rd_data1;

    logic [WIDX_W-1:0]      w;
    logic [WIDX_W-1:0]      w1;
    logic [OFF_W-1:0]       off;
    logic [WORD_BITS-1:0]   mask;
    logic [WORD_BITS-1:0]   lo;
    logic [WORD_BITS-1:0]   hi;
    logic [2*WORD_BITS-1:0] pair;
    logic [2*WORD_BITS-1:0] wd;
    logic [2*WORD_BITS-1:0] wm;
    logic [WORD_BITS-1:0]   new_lo;
    logic [WORD_BITS-1:0]   new_hi;
    logic [WORD_BITS-1:0]   rdata;
    logic                   we_lo;
    logic                   we_hi;
    logic                   we0;
    logic                   we1;
    logic [BANK_AW-1:0]     wr_addr0;
    logic [WORD_BITS-1:0]   wr_data0;
    logic [WORD_BITS-1:0]   wr_data1;

    assign o_pop = (r_state == ST_ISSUE) && !i_empty && (!r_out_valid || o_result.ready);

    // Even words sit in bank 0 and odd words in bank 1, so the two words of
    // one access always come from different banks.
    always_comb begin
        head_w   = i_head.start[OFF_W+WIDX_W-1:OFF_W];
        head_w1  = head_w + 1'b1;
        rd_addr1 = head_w[WIDX_W-1:1];
        rd_addr0 = head_w[0] ? head_w1[WIDX_W-1:1] : head_w[WIDX_W-1:1];
    end

    always_comb begin
        w     = r_cmd.start[OFF_W+WIDX_W-1:OFF_W];
        w1    = w + 1'b1;
        off   = r_cmd.start[OFF_W-1:0];
        mask  = count_mask(r_cmd.count);
        lo    = w[0] ? rd_data1 : rd_data0;
        hi    = w[0] ? rd_data0 : rd_data1;
        pair  = {hi, lo} >> off;
        rdata = pair[WORD_BITS-1:0] & mask;

        wd     = {{WORD_BITS{1'b0}}, r_cmd.value & mask} << off;
        wm     = {{WORD_BITS{1'b0}}, mask} << off;
        new_lo = (lo & ~wm[WORD_BITS-1:0]) | wd[WORD_BITS-1:0];
        new_hi = (hi & ~wm[2*WORD_BITS-1:WORD_BITS]) | wd[2*WORD_BITS-1:WORD_BITS];

        we_lo = (r_state == ST_EXEC) && (r_cmd.op == OP_WRITE) && (r_cmd.count != '0);
        we_hi = (r_state == ST_EXEC) && (r_cmd.op == OP_WRITE)
                && (wm[2*WORD_BITS-1:WORD_BITS] != '0);

        we0      = w[0] ? we_hi : we_lo;
        we1      = w[0] ? we_lo : we_hi;
        wr_addr0 = w[0] ? w1[WIDX_W-1:1] : w[WIDX_W-1:1];
        wr_data0 = w[0] ? new_hi : new_lo;
        wr_data1 = w[0] ? new_lo : new_hi;
    end

    bpsb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BANK_DEPTH)
    ) u_bank0 (
        .i_clk     (i_clk),
        .i_wr_en   (we0),
        .i_wr_addr (wr_addr0),
        .i_wr_data (wr_data0),
        .i_rd_addr (rd_addr0),
        .o_rd_data (rd_data0)
    );

    bpsb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BANK_DEPTH)
    ) u_bank1 (
        .i_clk     (i_clk),
        .i_wr_en   (we1),
        .i_wr_addr (w[WIDX_W-1:1]),
        .i_wr_data (wr_data1),
        .i_rd_addr (rd_addr1),
        .o_rd_data (rd_data1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ISSUE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_ISSUE: begin
                    if (r_out_valid && o_result.ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (o_pop) begin
                        r_cmd   <= i_head;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_out_valid <= 1'b1;
                    r_read_data <= (r_cmd.op == OP_READ) ? rdata : '0;
                    r_bits_done <= r_cmd.count;
                    r_position  <= r_cmd.position;
                    r_status    <= r_cmd.status;
                    r_state     <= ST_ISSUE;
                end
                default: begin
                    r_state <= ST_ISSUE;
                end
            endcase
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.read_data = r_read_data;
    assign o_result.bits_done = r_bits_done;
    assign o_result.position  = r_position;
    assign o_result.status    = r_status;

`ifndef ASSERT_OFF
    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> (r_state == ST_ISSUE && r_out_valid))
        else $error("storage engine stayed in execute");

    a_pop_starts_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_EXEC && !r_out_valid))
        else $error("command popped while the result slot was busy");

    a_write_only_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we0 || we1) |-> (r_state == ST_EXEC && r_cmd.op == OP_WRITE))
        else $error("store written outside an append");

    a_zero_count_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_bits_done == '0) |-> (r_read_data == '0))
        else $error("read data set with no bits read");
`endif

endmodule

/* design/bit_packed_stream_buffer.sv */
// An accepted transaction passes through the command queue, then the issue and
// execute states of the banked storage engine, which finishes one transaction
// before it pops the next and stalls while its result slot is still full.
// The request side takes up to two more transactions into its queue meanwhile.
// Reset clears length, read pointer, queue and result slot and sets capacity to
// 4096; store content is undefined until written and needs no clearing pass.
// ----------------------------------------------------------------------------
// Bit-packed stream buffer
// LSB-first bit stream store with append, clipped read and seek.
// ----------------------------------------------------------------------------
module bit_packed_stream_buffer
    import bpsb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [POS_W-1:0] i_cfg_wr_data,
    bpsb_in_if.sink          i_item,
    bpsb_out_if.source       o_result
);

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    bpsb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (i_item),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    bpsb_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    bpsb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_cmd),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule
